### design/hex_string_hamming_distance_top_assert.svh
// Assertion macros for the hex string Hamming distance block.
// Included by design/hex_string_hamming_distance_top.sv; relies on clk and rst in scope.
`ifndef HEX_STRING_HAMMING_DISTANCE_TOP_ASSERT_SVH
`define HEX_STRING_HAMMING_DISTANCE_TOP_ASSERT_SVH

// Checked only outside reset.
`define HSHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define HSHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/hshd_pkg.sv
// Shared types, ASCII constants and the nibble popcount table for the
// hex string Hamming distance block. No dependencies.
`timescale 1ns / 1ps

package hshd_pkg;

  localparam int unsigned SUM_W = 13;

  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_F = 8'h46;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_F = 8'h66;
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic             threshold_mode;
    logic [SUM_W-1:0] max_distance;
  } hshd_cfg_t;

  // Packed to match the result tdata layout, distance in the low bits.
  typedef struct packed {
    logic             bad_char;
    logic             within_limit;
    logic [SUM_W-1:0] distance;
  } hshd_result_t;

  function automatic logic [2:0] nibble_ones(input logic [3:0] n);
    logic [2:0] ones;
    case (n)
      4'h0: ones = 3'd0;
      4'h1, 4'h2, 4'h4, 4'h8: ones = 3'd1;
      4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC: ones = 3'd2;
      4'h7, 4'hB, 4'hD, 4'hE: ones = 3'd3;
      4'hF: ones = 3'd4;
      default: ones = 3'd0;
    endcase
    return ones;
  endfunction

endpackage

### design/hshd_hex_decode.sv
// Hex digit check and nibble decode for one ASCII character.
// Depends on hshd_pkg.
`timescale 1ns / 1ps

module hshd_hex_decode
  import hshd_pkg::*;
(
  input  logic [7:0] chr,
  output logic       is_hex,
  output logic [3:0] nibble
);

  logic [7:0] upper;
  logic [7:0] letter_val;
  logic [7:0] digit_val;

  assign is_hex = (chr >= CHR_ZERO    && chr <= CHR_NINE)    ||
                  (chr >= CHR_UPPER_A && chr <= CHR_UPPER_F) ||
                  (chr >= CHR_LOWER_A && chr <= CHR_LOWER_F);

  assign upper      = chr & ~CASE_BIT;
  assign letter_val = upper - CHR_UPPER_A + LETTER_BASE;
  assign digit_val  = chr - CHR_ZERO;
  assign nibble     = (chr > CHR_NINE) ? letter_val[3:0] : digit_val[3:0];

endmodule

### design/hshd_accum.sv
// Per-stream state: saturating bit-difference sum, error and limit latches,
// byte-equality flag, and the result of the final pair. Depends on hshd_pkg
// and hshd_hex_decode.
`timescale 1ns / 1ps

module hshd_accum
  import hshd_pkg::*;
#(
  parameter logic [SUM_W-1:0] SUM_CAP = 13'd4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   char_a,
  input  logic [7:0]   char_b,
  input  logic         last_char,
  input  hshd_cfg_t    cfg,
  output hshd_result_t result
);

  logic             hex_a;
  logic             hex_b;
  logic [3:0]       nib_a;
  logic [3:0]       nib_b;
  logic [2:0]       diff_bits;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_capped;

  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic             error_seen;
  logic             error_seen_next;
  logic             limit_exceeded;
  logic             limit_exceeded_next;
  logic             all_bytes_equal;
  logic             all_bytes_equal_next;

  hshd_hex_decode u_dec_a (.chr(char_a), .is_hex(hex_a), .nibble(nib_a));
  hshd_hex_decode u_dec_b (.chr(char_b), .is_hex(hex_b), .nibble(nib_b));

  assign diff_bits  = nibble_ones(nib_a ^ nib_b);
  assign sum_wide   = {1'b0, running_sum} + {{(SUM_W - 2){1'b0}}, diff_bits};
  assign sum_capped = (sum_wide > {1'b0, SUM_CAP}) ? SUM_CAP : sum_wide[SUM_W-1:0];

  always_comb begin
    running_sum_next     = running_sum;
    error_seen_next      = error_seen;
    limit_exceeded_next  = limit_exceeded;
    all_bytes_equal_next = all_bytes_equal && (char_a == char_b);

    // stopped streams skip validation and summing
    if (!error_seen && !limit_exceeded) begin
      if (!hex_a || !hex_b) begin
        error_seen_next = 1'b1;
      end else begin
        running_sum_next = sum_capped;
        if (cfg.threshold_mode && (sum_capped > cfg.max_distance)) begin
          limit_exceeded_next = 1'b1;
        end
      end
    end

    if (all_bytes_equal_next) begin
      result.distance     = '0;
      result.within_limit = 1'b1;
      result.bad_char     = 1'b0;
    end else if (error_seen_next) begin
      result.distance     = '0;
      result.within_limit = 1'b0;
      result.bad_char     = 1'b1;
    end else begin
      result.distance     = running_sum_next;
      result.within_limit = !limit_exceeded_next;
      result.bad_char     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      running_sum     <= '0;
      error_seen      <= 1'b0;
      limit_exceeded  <= 1'b0;
      all_bytes_equal <= 1'b1;
    end else if (step) begin
      running_sum     <= running_sum_next;
      error_seen      <= error_seen_next;
      limit_exceeded  <= limit_exceeded_next;
      all_bytes_equal <= all_bytes_equal_next;
    end
  end

endmodule

### design/hex_string_hamming_distance_top.sv
// Hex string Hamming distance. The last pair enters the input register, and the result
// register (m_tvalid) loads when that pair is processed. Throughput: one character pair
// per cycle while no last pair waits on a full result register, set by the single pass
// through decode, popcount and the 13-bit saturating add between the two registers.
// Reset (rst, synchronous, active high): both registers empty, stream state
// cleared, configuration registers back to 0. No clearing pass is needed.
`timescale 1ns / 1ps

`include "hex_string_hamming_distance_top_assert.svh"

module hex_string_hamming_distance_top
  import hshd_pkg::*;
#(
  parameter int unsigned MAX_CHARS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // character pair stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] char_a, [15:8] char_b
  input  logic        s_tlast,   // last_char
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [12:0] distance, [13] within_limit, [14] bad_char, [15] zero
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Saturation level: four bits per character, held within 13 bits.
  localparam longint unsigned CAP_RAW = 64'(MAX_CHARS) * 64'd4;
  localparam logic [SUM_W-1:0] SUM_CAP =
    (CAP_RAW > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(CAP_RAW);

  // Register select is paddr[2]: threshold_mode at 0x0, max_distance at 0x4.
  localparam logic REG_THRESHOLD_MODE = 1'b0;
  localparam logic REG_MAX_DISTANCE   = 1'b1;

  hshd_cfg_t    cfg;
  hshd_result_t result;

  // input register
  logic       in_valid;
  logic [7:0] in_a;
  logic [7:0] in_b;
  logic       in_last;

  logic out_free;
  logic step;
  logic cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_mode <= 1'b0;
      cfg.max_distance   <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_THRESHOLD_MODE: cfg.threshold_mode <= pwdata[0];
        REG_MAX_DISTANCE:   cfg.max_distance   <= pwdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD_MODE: prdata = {31'd0, cfg.threshold_mode};
      REG_MAX_DISTANCE:   prdata = {{(32 - SUM_W){1'b0}}, cfg.max_distance};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control. A pair in the input register is processed unless it is
  // the last of its stream and the result register is still occupied;
  // only the last pair needs the result slot, so others never stall.
  // ---------------------------------------------------------------------
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_a    <= s_tdata[7:0];
      in_b    <= s_tdata[15:8];
      in_last <= s_tlast;
    end
  end

  // Decode, popcount, saturating sum and latches.
  hshd_accum #(
    .SUM_CAP(SUM_CAP)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .char_a   (in_a),
    .char_b   (in_b),
    .last_char(in_last),
    .cfg      (cfg),
    .result   (result)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      m_tdata <= {1'b0, result};
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `HSHD_ASSERT(a_bad_char_clears_distance,
    m_tvalid && m_tdata[SUM_W+1] |-> (m_tdata[SUM_W-1:0] == '0) && !m_tdata[SUM_W],
    "bad_char result carries a distance or within flag")

  `HSHD_ASSERT(a_distance_capped,
    m_tvalid |-> (m_tdata[SUM_W-1:0] <= SUM_CAP),
    "distance above saturation level")

  `HSHD_ASSERT(a_stalled_pair_held,
    in_valid && !step |=> in_valid && $stable(in_a) && $stable(in_b) && $stable(in_last),
    "stalled pair lost or changed in input register")

  `HSHD_ASSERT(a_no_result_overwrite,
    m_tvalid && !m_tready |-> !(step && in_last),
    "last pair processed while result register still full")

  `HSHD_ASSERT_ALWAYS(a_reset_empties,
    rst |=> !m_tvalid && !in_valid,
    "registers not empty after reset")

endmodule

### sim/testbench.sv
// Self-checking testbench for hex_string_hamming_distance_top: character pair streams in,
// one Hamming distance result per stream out, checked against an in-bench predictor.
// Depends on hshd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import hshd_pkg::*;

  localparam int unsigned CHAR_LIMIT = 1024;
  // Saturation point of the running sum: four bits per character, held to 13 bits
  localparam int unsigned SUM_CAP = (4 * CHAR_LIMIT > SUM_MAX) ? SUM_MAX : 4 * CHAR_LIMIT;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // register byte addresses
  localparam logic [2:0] ADDR_THRESHOLD_MODE = 3'd0;
  localparam logic [2:0] ADDR_MAX_DISTANCE   = 3'd4;

  localparam logic [7:0] CHR_LOWER_X = 8'h78;

  typedef struct packed {
    logic       last;
    logic [7:0] b;
    logic [7:0] a;
  } pair_t;

  typedef enum {
    KIND_HEX,    // independent hex digits, mixed case
    KIND_EQUAL,  // byte-identical strings
    KIND_CASE,   // same digits, case differs at random
    KIND_NEAR,   // mostly equal, a few differing digits
    KIND_NOISY,  // hex with the odd arbitrary byte
    KIND_BYTES   // arbitrary bytes throughout
  } stream_kind_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [7:0] char_a, [15:8] char_b
  logic        s_tlast = 1'b0; // last_char
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [12:0] distance, [13] within_limit, [14] bad_char, [15] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hex_string_hamming_distance_top #(
    .MAX_CHARS(CHAR_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the stream state
  // ---------------------------------------------------------------------------
  logic        cfg_thresh = 1'b0;
  int unsigned cfg_max    = 0;

  int unsigned run_sum  = 0;
  bit          run_err  = 1'b0;
  bit          run_over = 1'b0;
  bit          run_same = 1'b1;

  pair_t        pair_queue[$];       // items waiting to be driven
  hshd_result_t distances_due[$];    // predicted results, oldest first
  pair_t        pair_on_bus;
  int unsigned  items_sent  = 0;
  int unsigned  items_taken = 0;
  int unsigned  mismatches  = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;

  function automatic bit hex_ok(input logic [7:0] c);
    return (c >= CHR_ZERO && c <= CHR_NINE) || (c >= CHR_UPPER_A && c <= CHR_UPPER_F) ||
           (c >= CHR_LOWER_A && c <= CHR_LOWER_F);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c > CHR_NINE) begin
      v = (c & ~CASE_BIT) - CHR_UPPER_A + LETTER_BASE;
    end else begin
      v = c - CHR_ZERO;
    end
    return v[3:0];
  endfunction

  // One accepted pair: update the stream state, queue a result on the last pair.
  // Once an error or an exceeded limit has stopped the stream, pairs only feed
  // the byte-equality check.
  task automatic hamming_step(input pair_t pr);
    hshd_result_t res;
    int unsigned bits;
    if (pr.a != pr.b) run_same = 1'b0;
    if (!run_err && !run_over) begin
      if (!hex_ok(pr.a) || !hex_ok(pr.b)) begin
        run_err = 1'b1;
      end else begin
        bits = $countones(hex_nibble(pr.a) ^ hex_nibble(pr.b));
        run_sum = run_sum + bits;
        if (run_sum > SUM_CAP) run_sum = SUM_CAP;
        if (cfg_thresh && run_sum > cfg_max) run_over = 1'b1;
      end
    end
    if (pr.last) begin
      res = '0;
      if (run_same) begin
        // byte-identical strings win over everything else
        res.within_limit = 1'b1;
      end else if (run_err) begin
        res.bad_char = 1'b1;
      end else begin
        res.distance     = run_sum[SUM_W-1:0];
        res.within_limit = !run_over;
      end
      distances_due.push_back(res);
      run_sum  = 0;
      run_err  = 1'b0;
      run_over = 1'b0;
      run_same = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 30) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes the next item from pair_queue once the bus is free.
  // The item just accepted goes to the predictor first.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        hamming_step(pair_on_bus);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pair_on_bus = pair_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {pair_on_bus.b, pair_on_bus.a};
          s_tlast  <= pair_on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each accepted result with the oldest prediction and
  // stalls the result stream at the current rate.
  // ---------------------------------------------------------------------------
  hshd_result_t got_res;
  hshd_result_t want_res;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res = hshd_result_t'(m_tdata[SUM_W+1:0]);
        if (distances_due.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", m_tdata));
        end else begin
          want_res = distances_due.pop_front();
          if (got_res.distance !== want_res.distance)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      got_res.distance, want_res.distance));
          if (got_res.within_limit !== want_res.within_limit)
            report_mismatch($sformatf("within_limit %b, expected %b",
                                      got_res.within_limit, want_res.within_limit));
          if (got_res.bad_char !== want_res.bad_char)
            report_mismatch($sformatf("bad_char %b, expected %b",
                                      got_res.bad_char, want_res.bad_char));
          if (m_tdata[15] !== 1'b0)
            report_mismatch("padding bit of result not zero");
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any handshake or register access counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pair(input logic [7:0] a, input logic [7:0] b, input bit last);
    pair_t pr;
    pr.a    = a;
    pr.b    = b;
    pr.last = last;
    pair_queue.push_back(pr);
    items_sent++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return CHR_ZERO + n;
    return (upper ? CHR_UPPER_A : CHR_LOWER_A) + n - LETTER_BASE;
  endfunction

  // Setup cycle then access cycle; the register takes the value at the access edge
  task automatic write_reg(input logic [2:0] addr, input int unsigned data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_THRESHOLD_MODE) cfg_thresh = data[0];
    else cfg_max = data & 32'h1FFF;
  endtask

  task automatic set_limits(input bit mode, input int unsigned dist_limit);
    write_reg(ADDR_THRESHOLD_MODE, mode);
    write_reg(ADDR_MAX_DISTANCE, dist_limit);
  endtask

  // Waits until every item is in and every result out, then lets the pipe settle
  // so that a stream left open cannot still be in flight at a register write.
  task automatic drain();
    while (items_taken != items_sent) @(posedge clk);
    while (distances_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_stream(input stream_kind_e kind, input int unsigned len,
                             input bit terminate);
    logic [3:0] na, nb;
    logic [7:0] ca, cb;
    for (int unsigned i = 0; i < len; i++) begin
      na = 4'($urandom_range(15));
      nb = 4'($urandom_range(15));
      case (kind)
        KIND_EQUAL, KIND_CASE: nb = na;
        KIND_NEAR: if ($urandom_range(3) != 0) nb = na;
        default: ;
      endcase
      ca = hex_char(na, 1'($urandom_range(1)));
      cb = (kind == KIND_EQUAL) ? ca : hex_char(nb, 1'($urandom_range(1)));
      if (kind == KIND_BYTES) begin
        ca = 8'($urandom_range(255));
        cb = ($urandom_range(3) == 0) ? ca : 8'($urandom_range(255));
      end else if (kind == KIND_NOISY && $urandom_range(7) == 0) begin
        if ($urandom_range(1)) ca = 8'($urandom_range(255));
        else cb = 8'($urandom_range(255));
      end
      push_pair(ca, cb, terminate && (i == len - 1));
    end
  endtask

  // Every pair differs in all four bits, so the sum runs into its ceiling
  task automatic push_saturating_stream();
    for (int unsigned i = 0; i < CHAR_LIMIT + 6; i++)
      push_pair(CHR_ZERO, (i % 2) ? CHR_UPPER_F : CHR_LOWER_F, i == CHAR_LIMIT + 5);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_items;
    int unsigned len;
    int unsigned pick;
    stream_kind_e kind;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, full-distance mode
    set_limits(1'b0, 0);
    push_pair(CHR_ZERO, CHR_ZERO, 1'b1);               // identical single pair
    push_pair(CHR_ZERO, CHR_UPPER_F, 1'b1);            // all four bits differ
    push_pair(CHR_LOWER_A, CHR_UPPER_A, 1'b1);         // bytes differ, digits equal
    push_pair(CHR_NINE, CHR_LOWER_A, 1'b0);
    push_pair(CHR_LOWER_F, CHR_ZERO, 1'b1);
    push_pair(CHR_ZERO - 8'd1, CHR_ZERO, 1'b1);        // just below '0'
    push_pair(CHR_NINE + 8'd1, CHR_NINE + 8'd1, 1'b1); // equal non-hex bytes
    push_pair(CHR_UPPER_A - 8'd1, CHR_UPPER_F + 8'd1, 1'b0);
    push_pair(CHR_LOWER_A - 8'd1, CHR_LOWER_F + 8'd1, 1'b1);
    push_pair(CHR_ZERO, 8'h80, 1'b1);                  // top bit set
    push_pair(CHR_LOWER_X, CHR_ZERO + 8'd1, 1'b0);     // error, then valid digits
    push_pair(CHR_ZERO + 8'd3, CHR_ZERO + 8'd4, 1'b1);
    push_pair(8'hFF, 8'hFF, 1'b0);
    push_pair(8'h00, 8'h00, 1'b1);
    push_pair(CHR_UPPER_A, CHR_LOWER_A, 1'b0);
    push_pair(CHR_UPPER_F, CHR_LOWER_F, 1'b0);
    push_pair(CHR_NINE, CHR_NINE, 1'b1);
    drain();

    // Directed, threshold mode at the tightest limit
    set_limits(1'b1, 0);
    push_pair(CHR_ZERO + 8'd1, CHR_ZERO, 1'b1);        // one bit over a zero limit
    push_pair(CHR_LOWER_F, CHR_ZERO, 1'b0);
    push_pair(CHR_LOWER_X, 8'h71, 1'b1);               // bad bytes after the stop
    push_pair(CHR_ZERO, CHR_ZERO, 1'b1);
    push_pair(CHR_UPPER_F + 8'd1, CHR_ZERO, 1'b1);
    drain();

    // Directed, threshold mode at the widest limit
    set_limits(1'b1, 8191);
    push_pair(CHR_ZERO, CHR_UPPER_F, 1'b0);
    push_pair(CHR_ZERO + 8'd7, CHR_ZERO + 8'd8, 1'b1);
    drain();

    // Random phases; the idle pattern rotates so that every phase of the
    // block's work sees gaps on both sides and also runs flat out
    for (int unsigned ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase

      pick = $urandom_range(5);
      if (ph == 4) set_limits(1'b0, $urandom_range(8191));
      else if (ph == 8) set_limits(1'b1, SUM_CAP);
      else if (pick == 0) set_limits(1'b0, 8191);
      else if (pick == 1) set_limits(1'b1, 0);
      else if (pick == 2) set_limits(1'b1, SUM_CAP);
      else if (pick == 3) set_limits(1'b1, $urandom_range(4096));
      else set_limits(1'b1, $urandom_range(40));

      // one long saturating stream, while nothing idles
      if (ph == 4) push_saturating_stream();

      phase_items = 0;
      while (phase_items < 40) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        pick = $urandom_range(99);
        if (pick < 40) kind = KIND_HEX;
        else if (pick < 52) kind = KIND_EQUAL;
        else if (pick < 62) kind = KIND_CASE;
        else if (pick < 78) kind = KIND_NEAR;
        else if (pick < 92) kind = KIND_NOISY;
        else kind = KIND_BYTES;
        push_stream(kind, len, 1'b1);
        phase_items += len;
      end
      // sometimes leave a stream open so the next settings apply mid-stream
      if (ph != 11 && $urandom_range(2) == 0)
        push_stream(KIND_HEX, $urandom_range(3, 1), 1'b0);
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && distances_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### hex_string_hamming_distance_top.f
+incdir+design
design/hshd_pkg.sv
design/hshd_hex_decode.sv
design/hshd_accum.sv
design/hex_string_hamming_distance_top.sv
sim/testbench.sv
